// ===== design/icmp_er_pkg.sv =====
// Package for the ICMP echo-reply classifier.
// Holds the verdict codes, protocol constants and the packet summary type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icmp_er_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned HdrW   = 6;
  localparam int unsigned VerdW  = 3;

  localparam logic [VerdW-1:0] VERDICT_ACCEPT    = 3'd0;
  localparam logic [VerdW-1:0] VERDICT_NOT_ICMP  = 3'd1;
  localparam logic [VerdW-1:0] VERDICT_TOO_SHORT = 3'd2;
  localparam logic [VerdW-1:0] VERDICT_NOT_REPLY = 3'd3;
  localparam logic [VerdW-1:0] VERDICT_WRONG_ID  = 3'd4;

  localparam logic [7:0]        PROTO_ICMP      = 8'd1;
  localparam logic [7:0]        TYPE_ECHO_REPLY = 8'd0;
  localparam logic [CountW-1:0] MIN_IP_LEN      = 16'd20;
  localparam logic [6:0]        MIN_ICMP_LEN    = 7'd8;
  localparam logic [CountW-1:0] PROTO_OFFSET    = 16'd9;
  localparam logic [6:0]        IDENT_HI_OFFSET = 7'd4;
  localparam logic [6:0]        IDENT_LO_OFFSET = 7'd5;
  localparam logic [CountW-1:0] COUNT_MAX       = 16'hFFFF;

  // Packet fields as they stand after the current byte has been taken in.
  typedef struct packed {
    logic [CountW-1:0] len;
    logic [HdrW-1:0]   header_bytes;
    logic [7:0]        protocol;
    logic [7:0]        message_type;
    logic [15:0]       echo_ident;
  } pkt_fields_t;

endpackage

`default_nettype wire

// ===== design/icmp_er_capture.sv =====
// Per-packet field capture for the ICMP echo-reply classifier.
// Counts bytes and picks out header length, protocol, type and identifier.
// Depends on icmp_er_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmp_er_capture (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last,
  output icmp_er_pkg::pkt_fields_t    fields
);

  logic [icmp_er_pkg::CountW-1:0] byte_count_r, byte_count_nxt;
  logic [icmp_er_pkg::HdrW-1:0]   header_bytes_r, header_bytes_nxt;
  logic [7:0]                     protocol_r, protocol_nxt;
  logic [7:0]                     message_type_r, message_type_nxt;
  logic [15:0]                    echo_ident_r, echo_ident_nxt;
  logic [6:0]                     hb_ext;

  always_comb begin
    header_bytes_nxt = header_bytes_r;
    if (byte_count_r == '0) begin
      header_bytes_nxt = {data_byte[3:0], 2'b00};
    end
    hb_ext = {1'b0, header_bytes_nxt};

    protocol_nxt     = protocol_r;
    message_type_nxt = message_type_r;
    echo_ident_nxt   = echo_ident_r;
    if (byte_count_r == icmp_er_pkg::PROTO_OFFSET) begin
      protocol_nxt = data_byte;
    end
    if (byte_count_r == {9'd0, hb_ext}) begin
      message_type_nxt = data_byte;
    end
    if (byte_count_r == {9'd0, hb_ext + icmp_er_pkg::IDENT_HI_OFFSET}) begin
      echo_ident_nxt[15:8] = data_byte;
    end
    if (byte_count_r == {9'd0, hb_ext + icmp_er_pkg::IDENT_LO_OFFSET}) begin
      echo_ident_nxt[7:0] = data_byte;
    end

    // The count saturates, so very long packets still read as long.
    byte_count_nxt = byte_count_r;
    if (byte_count_r != icmp_er_pkg::COUNT_MAX) begin
      byte_count_nxt = byte_count_r + 16'd1;
    end
  end

  assign fields.len          = byte_count_nxt;
  assign fields.header_bytes = header_bytes_nxt;
  assign fields.protocol     = protocol_nxt;
  assign fields.message_type = message_type_nxt;
  assign fields.echo_ident   = echo_ident_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      header_bytes_r <= '0;
      protocol_r     <= '0;
      message_type_r <= '0;
      echo_ident_r   <= '0;
    end else if (step) begin
      if (last) begin
        byte_count_r   <= '0;
        header_bytes_r <= '0;
        protocol_r     <= '0;
        message_type_r <= '0;
        echo_ident_r   <= '0;
      end else begin
        byte_count_r   <= byte_count_nxt;
        header_bytes_r <= header_bytes_nxt;
        protocol_r     <= protocol_nxt;
        message_type_r <= message_type_nxt;
        echo_ident_r   <= echo_ident_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/icmp_er_judge.sv =====
// Verdict logic for the ICMP echo-reply classifier.
// Applies the checks in priority order to the captured packet fields.
// Depends on icmp_er_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmp_er_judge (
  input  wire icmp_er_pkg::pkt_fields_t fields,
  input  wire logic [15:0]             expected_id,
  output logic [icmp_er_pkg::VerdW-1:0] verdict
);

  logic [6:0] icmp_min_len;

  assign icmp_min_len = {1'b0, fields.header_bytes} + icmp_er_pkg::MIN_ICMP_LEN;

  always_comb begin
    if (fields.len < icmp_er_pkg::MIN_IP_LEN) begin
      verdict = icmp_er_pkg::VERDICT_TOO_SHORT;
    end else if (fields.protocol != icmp_er_pkg::PROTO_ICMP) begin
      verdict = icmp_er_pkg::VERDICT_NOT_ICMP;
    end else if (fields.len < {9'd0, icmp_min_len}) begin
      verdict = icmp_er_pkg::VERDICT_TOO_SHORT;
    end else if (fields.message_type != icmp_er_pkg::TYPE_ECHO_REPLY) begin
      verdict = icmp_er_pkg::VERDICT_NOT_REPLY;
    end else if (fields.echo_ident != expected_id) begin
      verdict = icmp_er_pkg::VERDICT_WRONG_ID;
    end else begin
      verdict = icmp_er_pkg::VERDICT_ACCEPT;
    end
  end

endmodule

`default_nettype wire

// ===== design/icmp_echo_reply_classifier.sv =====
// ICMP echo-reply classifier, top level.
// Usage: an IPv4 packet enters one byte per transaction on the in_ channel
// (in_data_byte, with in_last on the final byte), starting at the first byte
// of the IP header. For every packet exactly one verdict transaction leaves on
// the out_ channel after the final byte; other bytes produce nothing.
// Verdicts: 0 accept, 1 not ICMP, 2 too short, 3 not echo reply, 4 wrong id.
// The identifier to accept is written through cfg_wr_en / cfg_wr_data, first
// wire byte in bits 15:8; write it only while no packet is in flight.
// Timing: a byte that is accepted is held in the input register; its verdict
// (if final) is then loaded into the output register and shows on out_valid /
// out_verdict from then on. Throughput is one byte per cycle while in_stall is
// low, set by the single input-register-to-output-register pass.
// Stalls: the output register holds its verdict while out_stall is high. A
// non-final byte never waits on the output, so in_stall only rises when a
// final byte sits in the input register and the output register is still
// full and stalled.
// Reset (rst_n low, synchronous) empties both registers, clears the packet
// state and sets the expected identifier to zero.
// Depends on icmp_er_pkg, icmp_er_capture and icmp_er_judge.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_reply_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [icmp_er_pkg::VerdW-1:0]      out_verdict,
  input  wire logic                          cfg_wr_en,
  input  wire logic [15:0]                   cfg_wr_data
);

  // Configured identifier.
  logic [15:0] expected_id_r;

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Output register stage.
  logic                          out_valid_r;
  logic [icmp_er_pkg::VerdW-1:0] out_verdict_r;

  logic                          out_free;
  logic                          s1_adv;
  logic                          s1_step;
  logic                          in_take;
  icmp_er_pkg::pkt_fields_t      fields;
  logic [icmp_er_pkg::VerdW-1:0] verdict;

  // The output slot is free when empty or when its verdict leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // A byte in the input register moves on unless it is final and the output
  // slot is occupied.
  assign s1_adv   = !s1_last_r || out_free;
  assign s1_step  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= '0;
    end else if (cfg_wr_en) begin
      expected_id_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last;
    end
  end

  icmp_er_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_step),
    .data_byte (s1_byte_r),
    .last      (s1_last_r),
    .fields    (fields)
  );

  icmp_er_judge u_judge (
    .fields      (fields),
    .expected_id (expected_id_r),
    .verdict     (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_step && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_step && s1_last_r) begin
      out_verdict_r <= verdict;
    end
  end

  // A final byte that moves on always lands a verdict in the output register.
  a_final_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    s1_step && s1_last_r |=> out_valid_r)
    else $error("final byte passed without a verdict");

  // Input backpressure only comes from a blocked final byte.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked final byte");

  // Only defined verdict codes leave the block.
  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_verdict_r <= icmp_er_pkg::VERDICT_WRONG_ID)
    else $error("undefined verdict code");

  // A non-final byte never creates a new verdict.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !(s1_step && s1_last_r) |=> !out_valid_r)
    else $error("verdict without a final byte");

endmodule

`default_nettype wire
